[rtl/process_slot_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Process slot scheduler assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SLOT_SCHEDULER_DEFINES_SVH
`define PROCESS_SLOT_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define PSS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PSS_ASSERT(label, clk, rst_n, prop, msg)
`define PSS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

[rtl/pss_pkg.sv]
// ----------------------------------------------------------------------------
// Process slot scheduler package
// Shared widths, command codes and the buses running along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  localparam int SlotCountDef = 32;
  localparam int MaxResults   = 32;
  localparam int SlotW        = 5;
  localparam int CountW       = 6;
  localparam int IdW          = 16;
  localparam int TickW        = 32;
  localparam int CmdW         = 3;
  localparam int InDataW      = 72;
  localparam int OutDataW     = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_KILL_SLOT = 3'd1,
    CMD_KILL_ID   = 3'd2,
    CMD_KILL_MASK = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_SLEEP     = 3'd5,
    CMD_STEP      = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  // command broadcast to every cell while it is in flight
  typedef struct packed {
    cmd_t             cmd;
    logic [IdW-1:0]   id;
    logic [IdW-1:0]   mask;
    logic [SlotW-1:0] target;
    logic [TickW-1:0] wake;
    logic [TickW-1:0] now;
  } cmd_bus_t;

  // running result handed from cell to cell with the token
  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } carry_t;

endpackage

`default_nettype wire

[rtl/process_slot_scheduler.sv]
// Timing: a command's final beat is registered once the token has walked the
//   whole cell row, one slot a cycle while the output side does not stall.
// Commands: one at a time; a new command is taken only once the last has finished.
//   Step beats leave as the token passes.
// Reset: rst_n synchronous, active low; clears all active flags, tick and control.
// ----------------------------------------------------------------------------
// Process slot scheduler
// Table of process slots held in a row of cells, with a global tick counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "process_slot_scheduler_defines.svh"

module process_slot_scheduler #(
  parameter int SLOT_COUNT = pss_pkg::SlotCountDef
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // command channel
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // tdata: proc_id[15:0], id_mask[31:16], target_slot[36:32], sleep_ticks[68:37]
  input  wire  [pss_pkg::InDataW-1:0]      in_tdata,
  // tuser: cmd[2:0]
  input  wire  [pss_pkg::CmdW-1:0]         in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // tdata: ok[0], result_slot[5:1], kill_count[11:6]
  output logic [pss_pkg::OutDataW-1:0]     out_tdata,
  output logic                             out_tlast
);

  localparam int SlotW   = pss_pkg::SlotW;
  localparam int CountW  = pss_pkg::CountW;
  localparam int TickW   = pss_pkg::TickW;
  localparam int PosW    = $clog2(SLOT_COUNT);
  localparam int NemitW  = $clog2(pss_pkg::MaxResults + 1);
  localparam int OutPadW = pss_pkg::OutDataW - 1 - SlotW - CountW;
  localparam logic [NemitW-1:0] NemitMax = NemitW'(pss_pkg::MaxResults);

  // control
  logic                         busy_r, busy_nxt;
  logic                         start_r, start_nxt;
  logic [PosW-1:0]              pos_r, pos_nxt;       // slot the token sits on
  logic [NemitW-1:0]            nemit_r, nemit_nxt;   // ready beats taken so far
  logic                         pend_v_r, pend_v_nxt; // held back until last is known
  logic [SlotW-1:0]             pend_slot_r, pend_slot_nxt;
  logic [TickW-1:0]             now_tick_r, now_tick_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pss_pkg::OutDataW-1:0] out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;
  pss_pkg::cmd_bus_t            cmd_r, cmd_nxt;

  logic                         in_accept;
  logic                         out_busy;
  logic                         hit_ok;
  logic                         adv;
  logic                         chain_done;
  logic                         chain_hit;
  pss_pkg::carry_t              chain_carry;
  pss_pkg::cmd_t                in_cmd;

  assign in_tready = !busy_r;
  assign in_accept = in_tvalid && in_tready;
  assign in_cmd    = pss_pkg::cmd_t'(in_tuser);

  pss_chain #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .start     (start_r),
    .cmd       (cmd_r),
    .carry_out (chain_carry),
    .done      (chain_done),
    .hit       (chain_hit)
  );

  always_comb begin
    out_busy = out_valid_r && !out_tready;
    // beyond the result cap further ready slots are dropped
    hit_ok   = chain_hit && (nemit_r != NemitMax);
    // freeze the whole row if a beat has nowhere to go
    adv      = !(out_busy && ((hit_ok && pend_v_r) || chain_done));

    busy_nxt      = busy_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    nemit_nxt     = nemit_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    now_tick_nxt  = now_tick_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cmd_nxt       = cmd_r;

    if (in_accept) begin
      cmd_nxt.cmd    = in_cmd;
      cmd_nxt.id     = in_tdata[15:0];
      // kill by id is a masked kill with every bit compared
      cmd_nxt.mask   = (in_cmd == pss_pkg::CMD_KILL_ID) ? '1 : in_tdata[31:16];
      cmd_nxt.target = in_tdata[36:32];
      cmd_nxt.wake   = (in_cmd == pss_pkg::CMD_SLEEP) ?
                       now_tick_r + in_tdata[68:37] : now_tick_r;
      cmd_nxt.now    = now_tick_r;
      busy_nxt       = 1'b1;
      start_nxt      = 1'b1;
      pos_nxt        = '0;
      nemit_nxt      = '0;
      pend_v_nxt     = 1'b0;
    end else if (busy_r && adv) begin
      start_nxt = 1'b0;
      pos_nxt   = pos_r + 1'b1;
      if (hit_ok) begin
        // previous ready slot is now known not to be the last
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {OutPadW'(0), CountW'(0), pend_slot_r, 1'b1};
          out_last_nxt  = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_slot_nxt = SlotW'(pos_r);
        nemit_nxt     = nemit_r + 1'b1;
      end
      if (chain_done) begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        busy_nxt      = 1'b0;
        pend_v_nxt    = 1'b0;
        if (cmd_r.cmd == pss_pkg::CMD_STEP) begin
          out_data_nxt = pend_v_r ? {OutPadW'(0), CountW'(0), pend_slot_r, 1'b1} : '0;
          now_tick_nxt = now_tick_r + 1'b1;
        end else begin
          out_data_nxt = {OutPadW'(0), chain_carry.count, chain_carry.slot,
                          chain_carry.found};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      pos_r       <= '0;
      nemit_r     <= '0;
      pend_v_r    <= 1'b0;
      now_tick_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
      nemit_r     <= nemit_nxt;
      pend_v_r    <= pend_v_nxt;
      now_tick_r  <= now_tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    cmd_r       <= cmd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a held-back ready slot only exists inside a command
  `PSS_ASSERT_NEVER(a_pend_idle, clk, rst_n, pend_v_r && !busy_r,
                    "pending ready slot outside a command")
  // never more ready beats than the cap
  `PSS_ASSERT(a_nemit_cap, clk, rst_n, nemit_r <= NemitMax,
              "ready beat count beyond cap")
  // finishing a command always leaves its final beat in the output register
  `PSS_ASSERT(a_fin_last, clk, rst_n, $fell(busy_r) |-> (out_valid_r && out_last_r),
              "command finished without a final beat")
  // an accepted command launches the token next cycle
  `PSS_ASSERT(a_launch, clk, rst_n, in_accept |=> (start_r && busy_r),
              "accepted command did not launch")

endmodule

`default_nettype wire

[rtl/pss_cell.sv]
// ----------------------------------------------------------------------------
// Process slot cell
// Holds one slot and applies the command when the token passes through it.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_cell #(
  parameter int IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   tok_in,
  input  pss_pkg::carry_t       carry_in,
  input  pss_pkg::cmd_bus_t     cmd,
  output logic                  tok_out,
  output pss_pkg::carry_t       carry_out,
  output logic                  hit
);

  localparam int SlotW = pss_pkg::SlotW;
  localparam bit Addressable = (IDX < (1 << SlotW));
  localparam logic [SlotW-1:0] IdxSlot = SlotW'(IDX);

  logic                        active_r, active_nxt;
  logic [pss_pkg::IdW-1:0]     owner_r, owner_nxt;
  logic [pss_pkg::TickW-1:0]   wake_r, wake_nxt;
  logic                        tok_r;
  pss_pkg::carry_t             carry_r, carry_nxt;
  logic                        sel;
  logic                        matched;

  always_comb begin
    carry_nxt  = carry_in;
    active_nxt = active_r;
    owner_nxt  = owner_r;
    wake_nxt   = wake_r;
    hit        = 1'b0;
    sel        = Addressable && (cmd.target == IdxSlot);
    matched    = (owner_r & cmd.mask) == (cmd.id & cmd.mask);
    if (tok_in) begin
      case (cmd.cmd)
        pss_pkg::CMD_CREATE: begin
          if (!carry_in.found && !active_r) begin
            active_nxt      = 1'b1;
            owner_nxt       = cmd.id;
            wake_nxt        = cmd.wake;
            carry_nxt.found = 1'b1;
            carry_nxt.slot  = IdxSlot;
          end
        end
        pss_pkg::CMD_KILL_SLOT: begin
          if (sel && active_r) begin
            active_nxt      = 1'b0;
            carry_nxt.count = carry_in.count + 1'b1;
          end
        end
        pss_pkg::CMD_KILL_ID, pss_pkg::CMD_KILL_MASK: begin
          if (active_r && matched) begin
            active_nxt      = 1'b0;
            carry_nxt.count = carry_in.count + 1'b1;
          end
        end
        pss_pkg::CMD_FIND: begin
          if (!carry_in.found && active_r && (owner_r == cmd.id)) begin
            carry_nxt.found = 1'b1;
            carry_nxt.slot  = IdxSlot;
          end
        end
        pss_pkg::CMD_SLEEP: begin
          if (sel) begin
            wake_nxt = cmd.wake;
          end
        end
        pss_pkg::CMD_STEP: begin
          hit = active_r && (wake_r <= cmd.now);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tok_r    <= 1'b0;
    end else if (adv) begin
      active_r <= active_nxt;
      tok_r    <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      owner_r <= owner_nxt;
      wake_r  <= wake_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign carry_out = carry_r;

endmodule

`default_nettype wire

[rtl/pss_chain.sv]
// ----------------------------------------------------------------------------
// Process slot cell row
// Strings the slot cells together; the token walks one cell per cycle while adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_chain #(
  parameter int SLOT_COUNT = pss_pkg::SlotCountDef
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   start,
  input  pss_pkg::cmd_bus_t     cmd,
  output pss_pkg::carry_t       carry_out,
  output logic                  done,
  output logic                  hit
);

  logic            tok   [SLOT_COUNT+1];
  pss_pkg::carry_t carry [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] hit_vec;

  assign tok[0]   = start;
  assign carry[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    pss_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .tok_in    (tok[i]),
      .carry_in  (carry[i]),
      .cmd       (cmd),
      .tok_out   (tok[i+1]),
      .carry_out (carry[i+1]),
      .hit       (hit_vec[i])
    );
  end

  assign done      = tok[SLOT_COUNT];
  assign carry_out = carry[SLOT_COUNT];
  assign hit       = |hit_vec;

endmodule

`default_nettype wire
